/* hw/rtl/tilt_to_hue_brightness_smoother_top_macros.svh */
// Assertion helpers shared by the smoother RTL.
`ifndef TILT_TO_HUE_BRIGHTNESS_SMOOTHER_TOP_MACROS_SVH
`define TILT_TO_HUE_BRIGHTNESS_SMOOTHER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, off while reset is high.
`define THBS_ASSERT(name, ck, rs, prop, msg) \
  name: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// Clocked check that also runs during reset.
`define THBS_ASSERT_ALWAYS(name, ck, prop, msg) \
  name: assert property (@(posedge ck) prop) else $error(msg);
`else
`define THBS_ASSERT(name, ck, rs, prop, msg)
`define THBS_ASSERT_ALWAYS(name, ck, prop, msg)
`endif

`endif

/* hw/rtl/thbs_pkg.sv */
package thbs_pkg;

  localparam int ACC_W     = 13;   // accelerometer sample width
  localparam int HUE_W     = 11;
  localparam int BR_W      = 9;
  localparam int NUM_W     = 20;   // 191 * 4096 fits
  localparam int DEN_W     = 13;
  localparam int DEPTH_DEF = 5;
  localparam int DEPTH_MAX = 16;

  localparam int HUE_STEP  = 191;
  localparam int HUE_B2    = 383;
  localparam int HUE_B3    = 765;
  localparam int HUE_B4    = 1148;
  localparam int HUE_MAX   = 1530;

  localparam int BR_OFS    = 63;   // 0x3F
  localparam int BR_SH     = 7;    // divide by 128
  localparam int BR_LIM    = 511;
  localparam int BR_CLAMP  = 510;

endpackage

/* hw/rtl/thbs_sample_if.sv */
interface thbs_sample_if;
  import thbs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    restart;
  logic                    tap;
  logic signed [ACC_W-1:0] accel_x;
  logic signed [ACC_W-1:0] accel_y;
  logic signed [ACC_W-1:0] accel_z;

  modport source (output valid, restart, tap, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, restart, tap, accel_x, accel_y, accel_z, output ready);
endinterface

/* hw/rtl/thbs_result_if.sv */
interface thbs_result_if;
  import thbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [BR_W-1:0]  brightness;
  logic             sampling;

  modport source (output valid, hue, brightness, sampling, input ready);
  modport sink   (input valid, hue, brightness, sampling, output ready);
endinterface

/* hw/rtl/tilt_to_hue_brightness_smoother_top.sv */
// Tilt to hue/brightness smoother.
// sample channel: one request per accelerometer reading (restart, tap, x, y, z).
// result channel: one request per accepted sample (averaged hue, brightness,
// sampling flag).
// A sample that leaves sampling off goes from accept straight to output load,
// and its result is valid once the output register is free.
// A sample taken while sampling goes through setup, a restoring divider for
// the tilt ratio, history write, a sweep of the history RAMs through their
// single read port, averaging (reciprocal multiply) and output load.
// The block works on one sample at a time; sample.ready is high while idle,
// also while a finished result still waits in the output register.
// If the receiver stalls, the next sample is still taken and processed, and
// its result waits until the output register drains.
// Reset: histories read as zero (per-entry valid bits), write slot 0, sampling
// off, saved hue and brightness zero, no result pending. No clearing pass.
// Restart clears the histories at once through the valid bits.
`include "tilt_to_hue_brightness_smoother_top_macros.svh"

module tilt_to_hue_brightness_smoother_top #(
  parameter int DEPTH = thbs_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  thbs_sample_if.sink    sample,
  thbs_result_if.source  result
);
  import thbs_pkg::*;

  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int HSUM_W = HUE_W + $clog2(DEPTH + 1);
  localparam int BSUM_W = BR_W + $clog2(DEPTH + 1);
  localparam int DCNT_W = $clog2(NUM_W);
  localparam int M_W    = 8;   // tilt ratio quotient is at most 191

  // sum / DEPTH as (sum * RECIP) >> RS, exact for any sum below 2**HSUM_W
  localparam int RS     = HSUM_W + ((DEPTH > 1) ? $clog2(DEPTH) : 0);
  localparam int RM_W   = RS + 1;
  localparam logic [RM_W-1:0] RECIP =
    RM_W'(((longint'(1) << RS) + longint'(DEPTH) - 1) / longint'(DEPTH));
  localparam int HP_W   = HSUM_W + RM_W;
  localparam int BP_W   = BSUM_W + RM_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_AVG   = 3'd5;
  localparam logic [2:0] ST_LOAD  = 3'd7;

  logic [2:0] state;

  // control
  logic             hold;
  logic [AW-1:0]    slot;
  logic [DEPTH-1:0] hue_vld;
  logic [DEPTH-1:0] br_vld;
  logic [CW-1:0]    rd_cnt;
  logic             rd_pend;
  logic             pend_hv;
  logic             pend_bv;
  logic             out_valid;

  // datapath
  logic signed [ACC_W-1:0] x_r, y_r, z_r;
  logic                    have_hue;
  logic                    hue_add;
  logic [HUE_W-1:0]        hue_base;
  logic [HSUM_W-1:0]       hsum;
  logic [BSUM_W-1:0]       bsum;
  logic [HUE_W-1:0]        saved_hue;
  logic [BR_W-1:0]         saved_br;
  logic [HUE_W-1:0]        out_hue;
  logic [BR_W-1:0]         out_br;
  logic                    out_samp;

  // divider
  logic [NUM_W-1:0]  dv_quo;
  logic [DEN_W-1:0]  dv_rem;
  logic [DEN_W-1:0]  dv_den;
  logic [DCNT_W-1:0] dv_cnt;
  logic [DEN_W:0]    dv_sh;
  logic [DEN_W:0]    dv_sub;
  logic              dv_ge;
  logic [DEN_W-1:0]  dv_rem_next;
  logic [NUM_W-1:0]  dv_quo_next;
  logic              dv_last;

  always_comb begin
    dv_sh       = {dv_rem, dv_quo[NUM_W-1]};
    dv_ge       = dv_sh >= {1'b0, dv_den};
    dv_sub      = dv_sh - {1'b0, dv_den};
    dv_rem_next = dv_ge ? dv_sub[DEN_W-1:0] : dv_sh[DEN_W-1:0];
    dv_quo_next = {dv_quo[NUM_W-2:0], dv_ge};
    dv_last     = dv_cnt == DCNT_W'(NUM_W - 1);
  end

  // tilt branch selection
  logic [ACC_W-1:0] ax, ay;
  logic             x_pos, x_neg, y_pos, y_neg, x_ge, y_ge;
  logic             br_dx, br_add, br_have;
  logic [HUE_W-1:0] br_base;
  logic [NUM_W-1:0] br_num;

  always_comb begin
    ax    = x_r[ACC_W-1] ? (~x_r + 1'b1) : x_r;
    ay    = y_r[ACC_W-1] ? (~y_r + 1'b1) : y_r;
    x_neg = x_r[ACC_W-1];
    y_neg = y_r[ACC_W-1];
    x_pos = !x_neg && (x_r != '0);
    y_pos = !y_neg && (y_r != '0);
    x_ge  = ax >= ay;
    y_ge  = ay >= ax;
    br_have = 1'b1;
    br_dx   = 1'b1;
    br_add  = 1'b0;
    br_base = '0;
    if (x_ge && x_pos && !y_neg) begin
      br_add = 1'b1;
    end else if (y_ge && y_pos) begin
      br_dx   = 1'b0;
      br_base = HUE_W'(HUE_B2);
      br_add  = !x_pos;
    end else if (x_ge && x_neg) begin
      br_base = HUE_W'(HUE_B3);
      br_add  = !y_pos;
    end else if (y_ge && y_neg) begin
      br_dx   = 1'b0;
      br_base = HUE_W'(HUE_B4);
      br_add  = x_pos;
    end else if (x_r != '0) begin
      br_base = HUE_W'(HUE_MAX);
    end else begin
      br_have = 1'b0;
    end
    br_num = NUM_W'(br_dx ? ay : ax) * NUM_W'(HUE_STEP);
  end

  // hue and brightness entries for the write step
  logic [M_W-1:0]           hue_m;
  logic [HUE_W:0]           hue_val;
  logic signed [ACC_W:0]    nz;
  logic signed [NUM_W-1:0]  bp;
  logic signed [NUM_W-1:0]  bq;
  logic signed [NUM_W-1:0]  bt;
  logic [BR_W-1:0]          br_val;

  always_comb begin
    hue_m   = dv_quo[M_W-1:0];
    hue_val = hue_add ? ({1'b0, hue_base} + (HUE_W+1)'(hue_m))
                      : ({1'b0, hue_base} - (HUE_W+1)'(hue_m));
    nz = -((ACC_W+1)'(z_r));
    bp = NUM_W'(nz) * NUM_W'(BR_OFS);
    // truncate toward zero
    bq = bp[NUM_W-1] ? ((bp + NUM_W'(127)) >>> BR_SH) : (bp >>> BR_SH);
    bt = bq + NUM_W'(BR_OFS);
    if (bt > NUM_W'(BR_LIM)) begin
      br_val = BR_W'(BR_CLAMP);
    end else if (bt[NUM_W-1]) begin
      br_val = '0;
    end else begin
      br_val = bt[BR_W-1:0];
    end
  end

  // history RAMs
  logic [HUE_W-1:0] rd_hue;
  logic [BR_W-1:0]  rd_br;
  logic [AW-1:0]    rd_addr;

  assign rd_addr = rd_cnt[AW-1:0];

  thbs_ram #(.WIDTH(HUE_W), .DEPTH(DEPTH)) u_hue_ram (
    .clk   (clk),
    .we    (state == ST_WRITE && have_hue),
    .waddr (slot),
    .wdata (hue_val[HUE_W-1:0]),
    .raddr (rd_addr),
    .rdata (rd_hue)
  );

  thbs_ram #(.WIDTH(BR_W), .DEPTH(DEPTH)) u_br_ram (
    .clk   (clk),
    .we    (state == ST_WRITE),
    .waddr (slot),
    .wdata (br_val),
    .raddr (rd_addr),
    .rdata (rd_br)
  );

  logic [HSUM_W-1:0] hsum_next;
  logic [BSUM_W-1:0] bsum_next;
  logic              rd_more;
  logic              out_free;
  logic              hold_next;
  logic [HP_W-1:0]   hprod;
  logic [BP_W-1:0]   bprod;

  always_comb begin
    hsum_next = hsum + ((rd_pend && pend_hv) ? HSUM_W'(rd_hue) : '0);
    bsum_next = bsum + ((rd_pend && pend_bv) ? BSUM_W'(rd_br) : '0);
    rd_more   = rd_cnt < CW'(DEPTH);
    out_free  = !out_valid || result.ready;
    hold_next = hold ^ sample.tap;
    hprod     = HP_W'(hsum) * HP_W'(RECIP);
    bprod     = BP_W'(bsum) * BP_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hold      <= 1'b1;
      slot      <= '0;
      hue_vld   <= '0;
      br_vld    <= '0;
      rd_cnt    <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      saved_hue <= '0;
      saved_br  <= '0;
    end else begin
      // the load step refills the output register itself
      if (out_valid && result.ready && state != ST_LOAD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            x_r  <= sample.accel_x;
            y_r  <= sample.accel_y;
            z_r  <= sample.accel_z;
            hold <= hold_next;
            if (sample.restart) begin
              hue_vld <= '0;
              br_vld  <= '0;
            end
            state <= hold_next ? ST_LOAD : ST_PREP;
          end
        end
        ST_PREP: begin
          have_hue <= br_have;
          hue_add  <= br_add;
          hue_base <= br_base;
          dv_quo   <= br_num;
          dv_den   <= br_dx ? ax : ay;
          dv_rem   <= '0;
          dv_cnt   <= '0;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          dv_quo <= dv_quo_next;
          dv_rem <= dv_rem_next;
          dv_cnt <= dv_cnt + 1'b1;
          if (dv_last) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (have_hue) begin
            hue_vld[slot] <= 1'b1;
          end
          br_vld[slot] <= 1'b1;
          slot   <= (slot == AW'(DEPTH - 1)) ? '0 : slot + 1'b1;
          hsum   <= '0;
          bsum   <= '0;
          rd_cnt <= '0;
          state  <= ST_SUM;
        end
        ST_SUM: begin
          hsum    <= hsum_next;
          bsum    <= bsum_next;
          rd_pend <= rd_more;
          if (rd_more) begin
            pend_hv <= hue_vld[rd_addr];
            pend_bv <= br_vld[rd_addr];
            rd_cnt  <= rd_cnt + 1'b1;
          end else begin
            // last read data arrives now
            state <= ST_AVG;
          end
        end
        ST_AVG: begin
          saved_hue <= hprod[RS +: HUE_W];
          saved_br  <= bprod[RS +: BR_W];
          state     <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_hue   <= saved_hue;
            out_br    <= saved_br;
            out_samp  <= !hold;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign sample.ready      = state == ST_IDLE;
  assign result.valid      = out_valid;
  assign result.hue        = out_hue;
  assign result.brightness = out_br;
  assign result.sampling   = out_samp;

  `THBS_ASSERT(a_hue_range, clk, rst, result.valid |-> result.hue <= HUE_W'(HUE_MAX), "hue above range")
  `THBS_ASSERT(a_hold_short, clk, rst, (sample.valid && sample.ready && (hold != sample.tap)) |=> state == ST_LOAD, "held sample did not go straight to output")
  `THBS_ASSERT(a_one_item, clk, rst, (sample.valid && sample.ready) |=> !sample.ready, "second request taken while busy")
  `THBS_ASSERT(a_out_wait, clk, rst, (state == ST_LOAD && result.valid && !result.ready) |=> state == ST_LOAD, "result overwritten while stalled")

endmodule

/* hw/rtl/thbs_ram.sv */
module thbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sim/tilt_to_hue_brightness_smoother_top_test.sv */
`timescale 1ns / 1ps

module tilt_to_hue_brightness_smoother_top_test;
  import thbs_pkg::*;

  localparam int RING          = DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 800;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 200;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [BR_W-1:0]  brightness;
    logic             sampling;
  } display_t;

  typedef struct {
    logic                    restart;
    logic                    tap;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
    bit                      fixed;   // want holds a hand-computed result
    display_t                want;
  } tilt_req_t;

  logic clk = 1'b0;
  logic rst;

  thbs_sample_if sample_ch ();
  thbs_result_if result_ch ();

  tilt_to_hue_brightness_smoother_top #(
    .DEPTH(RING)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // smoother state mirror
  logic [HUE_W-1:0] hue_ring [RING];
  logic [BR_W-1:0]  bright_ring [RING];
  int               ring_slot;
  bit               display_held;
  logic [HUE_W-1:0] held_hue;
  logic [BR_W-1:0]  held_bright;

  display_t  pending_display [$];
  tilt_req_t directed_reqs [$];
  display_t  got_display;
  int        error_count = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  logic      rx_hold = 1'b0;
  bit        pressure_go = 1'b0;

  function automatic display_t predict_display(tilt_req_t r);
    int       x, y, z, ax, ay, h, t, hue_sum, br_sum;
    bit       tilted;
    display_t d;
    if (r.restart) begin
      for (int i = 0; i < RING; i++) begin
        hue_ring[i] = '0;
        bright_ring[i] = '0;
      end
    end
    if (r.tap) display_held = !display_held;
    if (!display_held) begin
      x = r.accel_x;
      y = r.accel_y;
      z = -int'(r.accel_z);
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      tilted = 1'b1;
      h = 0;
      if (ax >= ay && x > 0 && y >= 0) begin
        h = (HUE_STEP * y) / x;
      end else if (ay >= ax && y > 0) begin
        h = HUE_B2 - (HUE_STEP * x) / y;
      end else if (ax >= ay && x < 0) begin
        h = HUE_B3 + (HUE_STEP * y) / x;
      end else if (ay >= ax && y < 0) begin
        h = HUE_B4 - (HUE_STEP * x) / y;
      end else if (x != 0) begin
        h = HUE_MAX + (HUE_STEP * y) / x;
      end else begin
        tilted = 1'b0;   // flat: hue entry keeps its old value
      end
      if (tilted) hue_ring[ring_slot] = h[HUE_W-1:0];
      t = (z * BR_OFS) / (1 << BR_SH) + BR_OFS;
      if (t > BR_LIM) t = BR_CLAMP;
      else if (t < 0) t = 0;
      bright_ring[ring_slot] = t[BR_W-1:0];
      hue_sum = 0;
      br_sum = 0;
      for (int i = 0; i < RING; i++) begin
        hue_sum += hue_ring[i];
        br_sum += bright_ring[i];
      end
      held_hue = HUE_W'(hue_sum / RING);
      held_bright = BR_W'(br_sum / RING);
      ring_slot = (ring_slot + 1) % RING;
    end
    d.hue = held_hue;
    d.brightness = held_bright;
    d.sampling = !display_held;
    return d;
  endfunction

  function automatic void add_row(bit rs, bit tp, int x, int y, int z, bit fixed = 1'b0,
                                  int hue = 0, int br = 0, bit samp = 1'b0);
    tilt_req_t r;
    r.restart = rs;
    r.tap = tp;
    r.accel_x = x[ACC_W-1:0];
    r.accel_y = y[ACC_W-1:0];
    r.accel_z = z[ACC_W-1:0];
    r.fixed = fixed;
    r.want.hue = hue[HUE_W-1:0];
    r.want.brightness = br[BR_W-1:0];
    r.want.sampling = samp;
    directed_reqs.push_back(r);
  endfunction

  function automatic logic signed [ACC_W-1:0] rand_axis();
    int v;
    case ($urandom_range(7))
      0: v = -4096;
      1: v = 4095;
      2: v = int'($urandom_range(6)) - 3;
      default: v = int'($urandom_range(8191)) - 4096;
    endcase
    return v[ACC_W-1:0];
  endfunction

  // mostly sampling on; taps and restarts are sparse, flat tilt now and then
  function automatic tilt_req_t random_req();
    tilt_req_t r;
    r.restart = ($urandom_range(31) == 0);
    if (display_held) r.tap = ($urandom_range(3) != 0);
    else r.tap = ($urandom_range(19) == 0);
    r.accel_x = rand_axis();
    r.accel_y = rand_axis();
    r.accel_z = rand_axis();
    if ($urandom_range(15) == 0) begin
      r.accel_x = '0;
      r.accel_y = '0;
    end
    r.fixed = 1'b0;
    r.want = '{default: '0};
    return r;
  endfunction

  task automatic offer_sample(tilt_req_t r);
    display_t d;
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.restart <= r.restart;
    sample_ch.tap     <= r.tap;
    sample_ch.accel_x <= r.accel_x;
    sample_ch.accel_y <= r.accel_y;
    sample_ch.accel_z <= r.accel_z;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    d = predict_display(r);
    if (r.fixed) d = r.want;
    pending_display.push_back(d);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver stall so the block backs up and stops taking requests
  initial begin
    wait (pressure_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_display.size() == 0) begin
        $error("result with no request outstanding: hue %0d brightness %0d sampling %0d",
               result_ch.hue, result_ch.brightness, result_ch.sampling);
        error_count++;
      end else begin
        got_display = pending_display.pop_front();
        if (result_ch.hue !== got_display.hue) begin
          $error("hue: expected %0d, actual %0d", got_display.hue, result_ch.hue);
          error_count++;
        end
        if (result_ch.brightness !== got_display.brightness) begin
          $error("brightness: expected %0d, actual %0d",
                 got_display.brightness, result_ch.brightness);
          error_count++;
        end
        if (result_ch.sampling !== got_display.sampling) begin
          $error("sampling: expected %0d, actual %0d",
                 got_display.sampling, result_ch.sampling);
          error_count++;
        end
      end
    end
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int phase_items;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.restart = 1'b0;
    sample_ch.tap = 1'b0;
    sample_ch.accel_x = '0;
    sample_ch.accel_y = '0;
    sample_ch.accel_z = '0;
    result_ch.ready = 1'b0;
    for (int i = 0; i < RING; i++) begin
      hue_ring[i] = '0;
      bright_ring[i] = '0;
    end
    ring_slot = 0;
    display_held = 1'b1;
    held_hue = '0;
    held_bright = '0;

    add_row(0, 0, 100, -200, 300, 1, 0, 0, 0);      // sampling off after reset
    add_row(0, 1, 4095, 0, 0, 1, 0, 12, 1);          // tap on, entry hue 0, bright 63 (average 12)
    add_row(0, 0, 4095, 4095, 0);
    add_row(0, 0, 0, 4095, -4096);                   // bright clamps high
    add_row(0, 0, -4095, 4095, 4095);                // bright clamps to zero
    add_row(0, 0, -4096, 0, 0);
    add_row(0, 0, -4096, -4096, 0);
    add_row(0, 0, 0, -4096, 0);
    add_row(0, 0, 4095, -4095, 0);
    add_row(0, 0, 4095, -1, 0);
    add_row(0, 0, 1, -4096, -1);
    add_row(0, 0, 0, 0, -4096);                      // flat tilt
    add_row(0, 0, -1, 1, 1);
    add_row(1, 0, 0, 0, 0, 1, 0, 12, 1);             // restart while sampling
    add_row(0, 1, 2000, 100, 0, 1, 0, 12, 0);        // tap off, values held
    add_row(1, 0, 300, 300, 300, 1, 0, 12, 0);       // restart while off keeps saved
    add_row(0, 0, -4096, 4095, 4095, 1, 0, 12, 0);
    add_row(0, 1, 0, 0, 0, 1, 0, 12, 1);             // back on, cleared histories
    add_row(1, 1, 4095, 0, 4095, 1, 0, 12, 0);       // restart and tap together
    add_row(1, 1, 1, 1, 0);
    add_row(0, 0, 2, -1, -1);
    add_row(0, 0, 4095, 4095, 4095);
    add_row(0, 0, -2, -4096, -4096);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 30;
    rx_idle_pct = 84;
    foreach (directed_reqs[i]) offer_sample(directed_reqs[i]);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        tx_idle_pct = 84;
        rx_idle_pct = 30;
      end else if (phase == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pressure_go = 1'b1;
      end
      phase_items = RANDOM_ITEMS / 3;
      for (int n = 0; n < phase_items; n++) offer_sample(random_req());
    end
    sample_ch.valid <= 1'b0;

    while (pending_display.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_display.size() != 0) begin
      $error("%0d results never arrived", pending_display.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
